### rtl/upf_pkg.sv
// Package: constants and types shared by the frame builder modules.
`timescale 1ns / 1ps

package upf_pkg;

    localparam int          MaxBytes   = 5;
    localparam int          IdxW       = 3;

    localparam logic [7:0]  OPEN_MARK  = 8'h3E;
    localparam logic [7:0]  CLOSE_MARK = 8'h3C;
    localparam logic [7:0]  SUM_INVERT = 8'hFF;

    localparam logic        MODE_HEADER = 1'b0;
    localparam logic        MODE_DATA   = 1'b1;

    // Bytes one item puts on the wire, with the index of the last one.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [IdxW-1:0]          last_idx;
        logic                     tail;
    } job_t;

endpackage

### rtl/upf_if.sv
// Interfaces: command item channel and transmit byte channel.
`timescale 1ns / 1ps

interface upf_cmd_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] msg_type;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, mode, msg_type, payload_length, data_byte, input ready);
    modport sink   (input valid, mode, msg_type, payload_length, data_byte, output ready);
endinterface

interface upf_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, out_byte, run_last, frame_end, input ready);
    modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

### rtl/upf_seq.sv
// Byte sequencer: holds one item's bytes and feeds them through the output register.
`timescale 1ns / 1ps

module upf_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_load,
    input  upf_pkg::job_t  job,
    output logic           job_free,
    upf_tx_if.source       tx
);

    upf_pkg::job_t                 job_reg;
    logic                          job_valid_reg;
    logic [upf_pkg::IdxW-1:0]      job_idx_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic                          run_last_reg;
    logic                          frame_end_reg;

    logic                          load_out;
    logic                          job_last;

    assign load_out = job_valid_reg && (!out_valid_reg || tx.ready);
    assign job_last = (job_idx_reg == job_reg.last_idx);
    assign job_free = !job_valid_reg || (load_out && job_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            job_idx_reg   <= '0;
        end
        else if (load_out)
        begin
            if (job_last)
                job_valid_reg <= 1'b0;
            else
                job_idx_reg <= job_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (tx.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg  <= job_reg.bytes[job_idx_reg];
            run_last_reg  <= job_last;
            frame_end_reg <= job_last && job_reg.tail;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.out_byte  = out_byte_reg;
    assign tx.run_last  = run_last_reg;
    assign tx.frame_end = frame_end_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> job_idx_reg <= job_reg.last_idx)
        else $error("byte index past end of item");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> job_free)
        else $error("item loaded over an unfinished one");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> run_last_reg)
        else $error("closing mark not last byte of its item");

endmodule

### rtl/uart_packet_framer_checksum.sv
// Top level: serial frame builder with additive checksum.
//
// Channels: cmd takes items (mode 0 = header with msg_type and
// payload_length, mode 1 = one payload byte); tx gives frame bytes with
// run_last on the last byte of each item and frame_end on the closing '<'.
// Frame: '>' type length data... checksum '<',
// checksum = ~(type + length + data bytes), 8 bits.
// A header opens a new frame (dropping any open one); a data item with no
// open frame is taken and gives no byte.
// Path: the byte holder is loaded when an item is accepted, and its first
// byte then moves into the output register, which drives tx; a stalled tx
// holds that move back while the output register is full.
// Throughput: one tx byte per cycle while tx.ready is high, set by the single
// output register; an item keeps the holder until its last byte moves out, so
// one-byte items flow at one per cycle and headers give 3 or 5 bytes.
// Reset: no frame open, holder and output register empty.
// Stall: when tx.ready is low the output byte holds, the holder fills and
// cmd.ready drops until the holder's last byte moves to the output register.
`timescale 1ns / 1ps

module uart_packet_framer_checksum (
    input  logic      clk,
    input  logic      rst_n,
    upf_cmd_if.sink   cmd,
    upf_tx_if.source  tx
);

    logic          frame_open_reg;
    logic          frame_open_next;
    logic [7:0]    bytes_left_reg;
    logic [7:0]    bytes_left_next;
    logic [7:0]    sum_acc_reg;
    logic [7:0]    sum_acc_next;

    logic          accept;
    logic          job_load;
    logic          job_free;
    upf_pkg::job_t job;
    logic [7:0]    sum_new;
    logic [7:0]    left_dec;

    assign cmd.ready = job_free;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        sum_acc_next    = sum_acc_reg;
        sum_new         = sum_acc_reg + cmd.data_byte;
        left_dec        = bytes_left_reg - 8'd1;
        job             = '0;
        job_load        = 1'b0;
        case (cmd.mode)
            upf_pkg::MODE_HEADER:
            begin
                sum_new         = cmd.msg_type + cmd.payload_length;
                sum_acc_next    = sum_new;
                bytes_left_next = cmd.payload_length;
                frame_open_next = (cmd.payload_length != 8'd0);
                job.bytes[0]    = upf_pkg::OPEN_MARK;
                job.bytes[1]    = cmd.msg_type;
                job.bytes[2]    = cmd.payload_length;
                job.bytes[3]    = sum_new ^ upf_pkg::SUM_INVERT;
                job.bytes[4]    = upf_pkg::CLOSE_MARK;
                job.tail        = (cmd.payload_length == 8'd0);
                job.last_idx    = job.tail ? upf_pkg::IdxW'(4) : upf_pkg::IdxW'(2);
                job_load        = accept;
            end
            upf_pkg::MODE_DATA:
            begin
                if (frame_open_reg)
                begin
                    sum_acc_next    = sum_new;
                    bytes_left_next = left_dec;
                    frame_open_next = (left_dec != 8'd0);
                    job.bytes[0]    = cmd.data_byte;
                    job.bytes[1]    = sum_new ^ upf_pkg::SUM_INVERT;
                    job.bytes[2]    = upf_pkg::CLOSE_MARK;
                    job.tail        = (left_dec == 8'd0);
                    job.last_idx    = job.tail ? upf_pkg::IdxW'(2) : upf_pkg::IdxW'(0);
                    job_load        = accept;
                end
            end
            default:
            begin
                job_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
            sum_acc_reg    <= 8'd0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            sum_acc_reg    <= sum_acc_next;
        end
    end

    upf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_load (job_load),
        .job      (job),
        .job_free (job_free),
        .tx       (tx)
    );

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> bytes_left_reg != 8'd0)
        else $error("open frame with no bytes left");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.mode == upf_pkg::MODE_DATA && !frame_open_reg |=>
            frame_open_reg == $past(frame_open_reg) && $stable(sum_acc_reg))
        else $error("dropped data item changed frame state");

    a_header_opens: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.mode == upf_pkg::MODE_HEADER |=>
            frame_open_reg == (bytes_left_reg != 8'd0))
        else $error("header left inconsistent frame state");

endmodule
